/* rtl/core/sfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and codes shared by the frame deframer core and its checker.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned HEADER_BYTES = 8;

	// accepted header prefixes, little-endian word of the first two bytes
	localparam logic [15:0] PREFIX_A = 16'h55AA;
	localparam logic [15:0] PREFIX_B = 16'h5AA5;

	// event codes
	localparam logic [2:0] EV_HEADER     = 3'd0;
	localparam logic [2:0] EV_PAYLOAD    = 3'd1;
	localparam logic [2:0] EV_GOOD       = 3'd2;
	localparam logic [2:0] EV_BAD_SUM    = 3'd3;
	localparam logic [2:0] EV_BAD_PREFIX = 3'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
	} sfd_in_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
		logic [15:0] command_word;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic        is_padding;
		logic [15:0] computed_sum;
		logic [15:0] received_sum;
	} sfd_out_t;

endpackage

/* rtl/core/sfd_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface sfd_stream_if #(
	parameter type item_t = logic [7:0]
);
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
	modport mon (input valid, input item, input ready);
endinterface

/* rtl/core/sum_checked_frame_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_core
// Byte stream deframer: 8-byte header with prefix check, padded data field,
// 16-bit additive checksum over header and data, good/bad frame report.
// ----------------------------------------------------------------------------
//  channel | dir | payload    | item
//  rx      | in  | sfd_in_t   | one received byte
//  res     | out | sfd_out_t  | header, payload byte, frame verdict or bad prefix
//
//  one byte per cycle unless stalled: parse state and the output register
//  both load at the accepting edge, so the event shows on res the cycle
//  after its byte; rx.ready is low only while a held event waits on res.ready
//  header bytes 0..6 and the first trailer byte produce no event
//  arst_n clears the parser to header hunt and empties the output register
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_core #(
	parameter int unsigned MIN_DATA_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	sfd_stream_if.sink   rx,
	sfd_stream_if.source res
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_DATA    = 2'd1;
	localparam logic [1:0] PH_TRAILER = 2'd2;

	localparam logic [15:0] MIN_LEN   = 16'(MIN_DATA_BYTES);
	localparam logic [15:0] LAST_HDR  = 16'(sfd_pkg::HEADER_BYTES - 1);

	logic [1:0]  phase_q;
	logic [15:0] pos_q;
	logic [7:0]  prefix_low_q, prefix_high_q, src_q, dst_q, trailer_low_q;
	logic [15:0] cmd_q, len_q, sum_q;

	logic             out_valid_q;
	sfd_pkg::sfd_out_t out_q;

	logic [1:0]  phase_n;
	logic [15:0] pos_n;
	logic [7:0]  prefix_low_n, prefix_high_n, src_n, dst_n, trailer_low_n;
	logic [15:0] cmd_n, len_n, sum_n;
	logic        emit;
	sfd_pkg::sfd_out_t ev;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] data_len;
	logic [15:0] pfx;
	logic [15:0] rx_sum;
	logic [16:0] idx_next;

	assign rx.ready  = !out_valid_q || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign b         = rx.item.rx_byte;
	assign data_len  = (len_q < MIN_LEN) ? MIN_LEN : len_q;
	assign pfx       = {prefix_high_q, prefix_low_q};
	assign rx_sum    = {b, trailer_low_q};
	assign idx_next  = {1'b0, pos_q} + 17'd1;

	always_comb begin
		phase_n       = phase_q;
		pos_n         = pos_q;
		prefix_low_n  = prefix_low_q;
		prefix_high_n = prefix_high_q;
		src_n         = src_q;
		dst_n         = dst_q;
		cmd_n         = cmd_q;
		len_n         = len_q;
		sum_n         = sum_q;
		trailer_low_n = trailer_low_q;
		emit          = 1'b0;
		ev            = '0;

		unique case (phase_q)
			PH_DATA: begin
				sum_n           = sum_q + 16'(b);
				emit            = 1'b1;
				ev.event_kind   = sfd_pkg::EV_PAYLOAD;
				ev.data_byte    = b;
				ev.byte_index   = pos_q;
				ev.is_padding   = (pos_q >= len_q);
				ev.computed_sum = sum_n;
				if (idx_next >= {1'b0, data_len}) begin
					phase_n = PH_TRAILER;
					pos_n   = '0;
				end else begin
					pos_n = idx_next[15:0];
				end
			end
			PH_TRAILER: begin
				if (pos_q == '0) begin
					trailer_low_n = b;
					pos_n         = 16'd1;
				end else begin
					emit            = 1'b1;
					ev.event_kind   = (rx_sum == sum_q) ? sfd_pkg::EV_GOOD
						: sfd_pkg::EV_BAD_SUM;
					ev.received_sum = rx_sum;
					ev.computed_sum = sum_q;
					phase_n         = PH_HEADER;
					pos_n           = '0;
					sum_n           = '0;
				end
			end
			default: begin
				// header hunt; the unused phase code restarts it from scratch
				logic [15:0] hpos;
				logic [15:0] hsum;
				hpos  = (phase_q == PH_HEADER) ? pos_q : '0;
				hsum  = ((phase_q == PH_HEADER) ? sum_q : '0) + 16'(b);
				sum_n = hsum;
				unique case (hpos)
					16'd0:   prefix_low_n  = b;
					16'd1:   prefix_high_n = b;
					16'd2:   src_n         = b;
					16'd3:   dst_n         = b;
					16'd4:   cmd_n         = {cmd_q[15:8], b};
					16'd5:   cmd_n         = {b, cmd_q[7:0]};
					16'd6:   len_n         = {len_q[15:8], b};
					default: len_n         = {b, len_q[7:0]};
				endcase
				phase_n = PH_HEADER;
				if (hpos < LAST_HDR) begin
					pos_n = hpos + 16'd1;
				end else begin
					emit            = 1'b1;
					ev.computed_sum = hsum;
					pos_n           = '0;
					if (pfx != sfd_pkg::PREFIX_A && pfx != sfd_pkg::PREFIX_B) begin
						ev.event_kind = sfd_pkg::EV_BAD_PREFIX;
						sum_n         = '0;
					end else begin
						ev.event_kind = sfd_pkg::EV_HEADER;
						phase_n       = PH_DATA;
					end
				end
			end
		endcase

		ev.source_id      = src_n;
		ev.dest_id        = dst_n;
		ev.command_word   = cmd_n;
		ev.payload_length = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			pos_q         <= '0;
			prefix_low_q  <= '0;
			prefix_high_q <= '0;
			src_q         <= '0;
			dst_q         <= '0;
			cmd_q         <= '0;
			len_q         <= '0;
			sum_q         <= '0;
			trailer_low_q <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			pos_q         <= pos_n;
			prefix_low_q  <= prefix_low_n;
			prefix_high_q <= prefix_high_n;
			src_q         <= src_n;
			dst_q         <= dst_n;
			cmd_q         <= cmd_n;
			len_q         <= len_n;
			sum_q         <= sum_n;
			trailer_low_q <= trailer_low_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_q <= ev;
		end
	end

	assign res.valid = out_valid_q;
	assign res.item  = out_q;

endmodule

/* rtl/core/sfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer event stream.
// ----------------------------------------------------------------------------
module sfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input sfd_pkg::sfd_out_t res_item
);

	// a stalled event holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("event changed while stalled");

	// byte fields are zero outside payload events
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.event_kind != sfd_pkg::EV_PAYLOAD |->
		res_item.data_byte == '0 && res_item.byte_index == '0 && !res_item.is_padding)
		else $error("payload fields set on non-payload event");

	// verdict matches the carried and computed sums
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.event_kind == sfd_pkg::EV_GOOD |->
		res_item.received_sum == res_item.computed_sum)
		else $error("good frame with mismatched sums");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.event_kind == sfd_pkg::EV_BAD_SUM |->
		res_item.received_sum != res_item.computed_sum)
		else $error("bad frame with matching sums");

	// padding flag agrees with index and declared length
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.event_kind == sfd_pkg::EV_PAYLOAD |->
		res_item.is_padding == (res_item.byte_index >= res_item.payload_length))
		else $error("padding flag inconsistent");

endmodule

bind sum_checked_frame_deframer_core sfd_checker u_sfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.item)
);
